FILE: rtl/grtr_pkg.sv
// ----------------------------------------------------------------------------
// grtr_pkg
// Shared types and constants of the glyph row text renderer: default sizes,
// configuration register indexes, item codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package grtr_pkg;

    localparam int STORE_BYTES_DEF     = 16384;
    localparam int MAX_GLYPH_ROWS_DEF  = 32;
    localparam int MAX_GLYPH_WIDTH_DEF = 16;

    // Widest value the store index reduction has to take (character times
    // bytes per glyph).
    localparam int RED_W = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_GLYPH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_BASE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_PITCH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB_ENABLE      = 3'd7;

    localparam logic [4:0]  GLYPH_WIDTH_RST     = 5'd8;
    localparam logic [5:0]  GLYPH_HEIGHT_RST    = 6'd16;
    localparam logic [6:0]  BYTES_PER_GLYPH_RST = 7'd16;
    localparam logic [31:0] FB_PITCH_RST        = 32'd4096;
    localparam logic [15:0] FB_WIDTH_RST        = 16'd1024;
    localparam logic [5:0]  BITS_PER_PIXEL_RST  = 6'd32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_WRITE,
        ST_BASE,
        ST_COL,
        ST_ROW_A,
        ST_ROW_B,
        ST_ROW_C,
        ST_ADV
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/glyph_row_text_renderer.sv
// ----------------------------------------------------------------------------
// glyph_row_text_renderer
// Bitmap-font text console: glyph store, text cursor and one result per
// glyph row with the framebuffer address and the pixel mask of the row.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready until the item is
// done. A load item runs the compare and subtract steps of the shared
// store index reduction (RED_STEPS of them, 2 for a 16384-byte store),
// then writes the byte. A draw item runs the multiply state, the
// reduction, the base and column states, the row states (none for a glyph
// of zero height) and the cursor update. Each row is emitted from ST_ROW_C;
// glyphs wider than 8 pixels also pass ST_ROW_B, as the single store read
// port delivers one byte per cycle. A stalled result channel holds ST_ROW_C.
// A newline, or a draw while the framebuffer is disabled, is handled in the
// idle state. The glyph store is not cleared after reset.
`default_nettype none

module glyph_row_text_renderer #(
    parameter int STORE_BYTES     = grtr_pkg::STORE_BYTES_DEF,
    parameter int MAX_GLYPH_ROWS  = grtr_pkg::MAX_GLYPH_ROWS_DEF,
    parameter int MAX_GLYPH_WIDTH = grtr_pkg::MAX_GLYPH_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [grtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [grtr_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_op,
    input  wire logic [7:0]                     s_character,
    input  wire logic [13:0]                    s_store_index,
    input  wire logic [7:0]                     s_store_byte,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [63:0]                         m_pixel_address,
    output logic [15:0]                         m_pixel_mask,
    output logic                                m_last_row
);

    import grtr_pkg::*;

    localparam int SB_AW     = $clog2(STORE_BYTES);
    localparam int RED_STEPS = (RED_W > SB_AW - 1) ? (RED_W - SB_AW + 1) : 1;
    localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int CMP_W     = RED_W + SB_AW + 1;

    localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(RED_STEPS - 1);
    localparam logic [CMP_W-1:0]  DIV_INIT  = CMP_W'(STORE_BYTES) << (RED_STEPS - 1);
    localparam logic [SB_AW:0]    STORE_LIM = (SB_AW + 1)'(STORE_BYTES);

    state_t state_reg, state_next;

    logic [4:0]  gw_reg, gw_next;
    logic [5:0]  gh_reg, gh_next;
    logic [6:0]  bpg_reg, bpg_next;
    logic [63:0] fb_base_reg, fb_base_next;
    logic [31:0] fb_pitch_reg, fb_pitch_next;
    logic [15:0] fb_width_reg, fb_width_next;
    logic [5:0]  bpp_reg, bpp_next;
    logic        fb_en_reg, fb_en_next;

    logic [31:0] cursor_x_reg, cursor_x_next;
    logic [31:0] cursor_y_reg, cursor_y_next;

    logic              op_reg, op_next;
    logic [7:0]        char_reg, char_next;
    logic [7:0]        byte_reg, byte_next;
    logic [CMP_W-1:0]  red_reg, red_next;
    logic [CMP_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [63:0]       prod_y_reg, prod_y_next;
    logic [37:0]       prod_x_reg, prod_x_next;
    logic [63:0]       addr_reg, addr_next;
    logic [SB_AW-1:0]  ptr_reg, ptr_next;
    logic [5:0]        row_reg, row_next;
    logic [7:0]        b0_reg, b0_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_addr_reg, out_addr_next;
    logic [15:0] out_mask_reg, out_mask_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]       mem [STORE_BYTES];
    logic [7:0]       mem_q;
    logic             rd_en;
    logic [SB_AW-1:0] rd_addr;
    logic             mem_we;

    logic [4:0]       eff_w;
    logic [5:0]       eff_h;
    logic [2:0]       stride;
    logic             wide;
    logic [SB_AW:0]   sum_stride;
    logic [SB_AW:0]   sum_one;
    logic [SB_AW-1:0] ptr_plus_stride;
    logic [SB_AW-1:0] ptr_plus_one;
    logic             row_last;
    logic             out_free;
    logic [7:0]       byte0;
    logic [15:0]      raw_mask;
    logic [15:0]      width_mask;
    logic [31:0]      cx_adv;
    logic             wrap;

    always_comb begin
        eff_w = (32'(gw_reg) > MAX_GLYPH_WIDTH) ? 5'(MAX_GLYPH_WIDTH) : gw_reg;
        eff_h = (32'(gh_reg) > MAX_GLYPH_ROWS) ? 6'(MAX_GLYPH_ROWS) : gh_reg;
        stride = 3'((6'(eff_w) + 6'd7) >> 3);
        wide = eff_w > 5'd8;

        sum_stride = {1'b0, ptr_reg} + (SB_AW + 1)'(stride);
        ptr_plus_stride = (sum_stride >= STORE_LIM) ? SB_AW'(sum_stride - STORE_LIM)
                                                    : SB_AW'(sum_stride);
        sum_one = {1'b0, ptr_reg} + (SB_AW + 1)'(1);
        ptr_plus_one = (sum_one >= STORE_LIM) ? SB_AW'(sum_one - STORE_LIM)
                                              : SB_AW'(sum_one);

        row_last = (row_reg + 6'd1) == eff_h;
        out_free = !out_valid_reg || m_ready;

        // Glyph rows are stored MSB first: pixel i is bit 7 - i of its byte.
        byte0 = wide ? b0_reg : mem_q;
        for (int i = 0; i < 8; i++) begin
            raw_mask[i]     = byte0[7 - i];
            raw_mask[8 + i] = mem_q[7 - i];
        end
        width_mask = (eff_w >= 5'd16) ? 16'hffff : 16'((17'd1 << eff_w) - 17'd1);

        cx_adv = cursor_x_reg + 32'(eff_w);
        wrap = (cx_adv + 32'(eff_h)) >= (32'(fb_width_reg) - 32'(eff_h >> 1));
    end

    always_comb begin
        state_next    = state_reg;
        gw_next       = gw_reg;
        gh_next       = gh_reg;
        bpg_next      = bpg_reg;
        fb_base_next  = fb_base_reg;
        fb_pitch_next = fb_pitch_reg;
        fb_width_next = fb_width_reg;
        bpp_next      = bpp_reg;
        fb_en_next    = fb_en_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        op_next       = op_reg;
        char_next     = char_reg;
        byte_next     = byte_reg;
        red_next      = red_reg;
        div_next      = div_reg;
        step_next     = step_reg;
        prod_y_next   = prod_y_reg;
        prod_x_next   = prod_x_reg;
        addr_next     = addr_reg;
        ptr_next      = ptr_reg;
        row_next      = row_reg;
        b0_next       = b0_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_addr_next  = out_addr_reg;
        out_mask_next  = out_mask_reg;
        out_last_next  = out_last_reg;
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        mem_we  = 1'b0;

        cfg_ready = 1'b1;
        s_ready   = state_reg == ST_IDLE;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GLYPH_WIDTH:     gw_next       = cfg_data[4:0];
                REG_GLYPH_HEIGHT:    gh_next       = cfg_data[5:0];
                REG_BYTES_PER_GLYPH: bpg_next      = cfg_data[6:0];
                REG_FB_BASE:         fb_base_next  = cfg_data;
                REG_FB_PITCH:        fb_pitch_next = cfg_data[31:0];
                REG_FB_WIDTH:        fb_width_next = cfg_data[15:0];
                REG_BITS_PER_PIXEL:  bpp_next      = cfg_data[5:0];
                REG_FB_ENABLE:       fb_en_next    = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next   = s_op;
                    char_next = s_character;
                    byte_next = s_store_byte;
                    if (s_op == OP_LOAD) begin
                        red_next   = CMP_W'(s_store_index);
                        div_next   = DIV_INIT;
                        step_next  = STEP_INIT;
                        state_next = ST_RED;
                    end else if (fb_en_reg) begin
                        if (s_character == NEWLINE_CODE) begin
                            cursor_x_next = 32'd0;
                            cursor_y_next = cursor_y_reg + 32'(eff_h);
                        end else begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                prod_y_next = {32'd0, cursor_y_reg} * {32'd0, fb_pitch_reg};
                prod_x_next = {6'd0, cursor_x_reg} * {32'd0, bpp_reg};
                red_next    = CMP_W'({7'd0, char_reg} * {8'd0, bpg_reg});
                div_next    = DIV_INIT;
                step_next   = STEP_INIT;
                state_next  = ST_RED;
            end
            ST_RED: begin
                if (red_reg >= div_reg) begin
                    red_next = red_reg - div_reg;
                end
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = (op_reg == OP_LOAD) ? ST_WRITE : ST_BASE;
                end
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BASE: begin
                addr_next  = fb_base_reg + prod_y_reg;
                ptr_next   = SB_AW'(red_reg);
                row_next   = 6'd0;
                state_next = ST_COL;
            end
            ST_COL: begin
                addr_next  = addr_reg + 64'(prod_x_reg >> 3);
                state_next = (eff_h == 6'd0) ? ST_ADV : ST_ROW_A;
            end
            ST_ROW_A: begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = wide ? ST_ROW_B : ST_ROW_C;
            end
            ST_ROW_B: begin
                b0_next    = mem_q;
                rd_en      = 1'b1;
                rd_addr    = ptr_plus_one;
                state_next = ST_ROW_C;
            end
            ST_ROW_C: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_addr_next  = addr_reg;
                    out_mask_next  = raw_mask & width_mask;
                    out_last_next  = row_last;
                    addr_next      = addr_reg + {32'd0, fb_pitch_reg};
                    row_next       = row_reg + 6'd1;
                    ptr_next       = ptr_plus_stride;
                    if (row_last) begin
                        state_next = ST_ADV;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_plus_stride;
                        state_next = wide ? ST_ROW_B : ST_ROW_C;
                    end
                end
            end
            ST_ADV: begin
                if (wrap) begin
                    cursor_x_next = 32'd0;
                    cursor_y_next = cursor_y_reg + 32'(eff_h);
                end else begin
                    cursor_x_next = cx_adv;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gw_reg        <= GLYPH_WIDTH_RST;
            gh_reg        <= GLYPH_HEIGHT_RST;
            bpg_reg       <= BYTES_PER_GLYPH_RST;
            fb_base_reg   <= 64'd0;
            fb_pitch_reg  <= FB_PITCH_RST;
            fb_width_reg  <= FB_WIDTH_RST;
            bpp_reg       <= BITS_PER_PIXEL_RST;
            fb_en_reg     <= 1'b0;
            cursor_x_reg  <= 32'd0;
            cursor_y_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gw_reg        <= gw_next;
            gh_reg        <= gh_next;
            bpg_reg       <= bpg_next;
            fb_base_reg   <= fb_base_next;
            fb_pitch_reg  <= fb_pitch_next;
            fb_width_reg  <= fb_width_next;
            bpp_reg       <= bpp_next;
            fb_en_reg     <= fb_en_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        char_reg     <= char_next;
        byte_reg     <= byte_next;
        red_reg      <= red_next;
        div_reg      <= div_next;
        step_reg     <= step_next;
        prod_y_reg   <= prod_y_next;
        prod_x_reg   <= prod_x_next;
        addr_reg     <= addr_next;
        ptr_reg      <= ptr_next;
        row_reg      <= row_next;
        b0_reg       <= b0_next;
        out_addr_reg <= out_addr_next;
        out_mask_reg <= out_mask_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[SB_AW'(red_reg)] <= byte_reg;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_pixel_mask    = out_mask_reg;
    assign m_last_row      = out_last_reg;

endmodule

`default_nettype wire
